// File: rtl/arp_request_responder_top_defines.svh
// Assertion macros shared by the ARP request responder RTL.
// Relies on clk_i and rst_ni being visible in the including module.
`ifndef ARP_REQUEST_RESPONDER_TOP_DEFINES_SVH
`define ARP_REQUEST_RESPONDER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ARP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ARP responder assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ARP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ARP responder assertion failed");

`endif

// File: rtl/arp_rr_pkg.sv
// Constants and helper functions of the ARP request responder.
// No dependencies.
`default_nettype none

package arp_rr_pkg;

  localparam int unsigned HdrBytes = 42;
  localparam int unsigned HdrAddrW = 6;

  localparam logic [7:0] EtherTypeHi = 8'h08;
  localparam logic [7:0] EtherTypeLo = 8'h06;
  localparam logic [7:0] HwAddrLen   = 8'd6;
  localparam logic [7:0] ProtoLen    = 8'd4;
  localparam logic [7:0] OpReplyHi   = 8'h00;
  localparam logic [7:0] OpReplyLo   = 8'h02;

  localparam logic [1:0] CfgLocalIp  = 2'd0;
  localparam logic [1:0] CfgLocalMac = 2'd1;

  // Header store address that feeds reply byte k.
  function automatic logic [HdrAddrW-1:0] src_addr(input logic [HdrAddrW-1:0] k);
    logic [HdrAddrW-1:0] a;
    case (k) inside
      [6'd0:6'd5]:   a = k + 6'd6;
      [6'd28:6'd31]: a = k + 6'd10;
      [6'd32:6'd41]: a = k - 6'd10;
      default:       a = k;
    endcase
    return a;
  endfunction

  // Byte j of a MAC address in wire order, most significant byte first.
  function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] j);
    logic [7:0] b;
    case (j)
      3'd0:    b = mac[47:40];
      3'd1:    b = mac[39:32];
      3'd2:    b = mac[31:24];
      3'd3:    b = mac[23:16];
      3'd4:    b = mac[15:8];
      default: b = mac[7:0];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: rtl/arp_rr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module arp_rr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 42,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/arp_request_responder_top.sv
// ARP request responder: accepts one frame byte per cycle while idle.
// After the last byte of a matching request, the reply is read from the header
// RAM and the 42 reply bytes follow at up to one per cycle, as reply_ready_i allows,
// paced by the single read port of the header RAM; input is held off meanwhile.
// Reset (rst_ni low, asynchronous) clears the byte counter, the control state,
// issue_k_q, the valid flags and the configuration; the header RAM is not cleared.
`default_nettype none
`include "arp_request_responder_top_defines.svh"

module arp_request_responder_top
  import arp_rr_pkg::*;
#(
  parameter int unsigned LENGTH_COUNTER_BITS = 11
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Received frame, one byte per transfer.
  input  wire logic [7:0]  frame_byte_i,
  input  wire logic        frame_last_i,
  input  wire logic        frame_valid_i,
  output logic             frame_ready_o,
  // ARP reply, one byte per transfer.
  output logic      [7:0]  reply_byte_o,
  output logic             reply_last_o,
  output logic             reply_valid_o,
  input  wire logic        reply_ready_i,
  // Configuration writes.
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [47:0] cfg_data_i
);

  localparam logic StIdle = 1'b0;
  localparam logic StEmit = 1'b1;

  localparam logic [HdrAddrW-1:0] LastIdx = HdrAddrW'(HdrBytes - 1);

  // Configuration registers.
  logic [31:0] local_ip_q;
  logic [47:0] local_mac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ip_q  <= '0;
      local_mac_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgLocalIp:  local_ip_q  <= cfg_data_i[31:0];
        CfgLocalMac: local_mac_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Receive side. Each transfer bumps the saturating byte counter, or clears it
  // on the last byte; the first 42 bytes go to the header RAM. The ethertype check
  // and target address bytes are tracked on the fly: no RAM read at the last byte.
  logic                           state_q, state_d;
  logic [LENGTH_COUNTER_BITS-1:0] count_q, count_d, count_inc;
  logic                           eth_ok_q;
  logic [31:0]                    ip_cap_q, ip_now;
  logic                           in_xfer, in_ip_win, reply_due;

  assign frame_ready_o = (state_q == StIdle);
  assign in_xfer       = frame_valid_i && frame_ready_o;

  assign count_inc = (count_q == '1) ? count_q : count_q + LENGTH_COUNTER_BITS'(1);
  assign in_ip_win = (count_q >= LENGTH_COUNTER_BITS'(38)) &&
                     (count_q <= LENGTH_COUNTER_BITS'(41));
  // The target address as of this byte, including the byte itself.
  assign ip_now    = in_ip_win ? {ip_cap_q[23:0], frame_byte_i} : ip_cap_q;

  // A frame of 42 bytes or more has passed bytes 12, 13 and 38 to 41, so the
  // flags belong to this frame whenever the length test passes.
  assign reply_due = in_xfer && frame_last_i &&
                     (count_inc >= LENGTH_COUNTER_BITS'(HdrBytes)) &&
                     eth_ok_q && (ip_now == local_ip_q);

  always_comb begin
    count_d = count_q;
    if (in_xfer) begin
      count_d = frame_last_i ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      if (count_q == LENGTH_COUNTER_BITS'(12)) begin
        eth_ok_q <= (frame_byte_i == EtherTypeHi);
      end else if (count_q == LENGTH_COUNTER_BITS'(13)) begin
        eth_ok_q <= eth_ok_q && (frame_byte_i == EtherTypeLo);
      end
      if (in_ip_win) begin
        ip_cap_q <= ip_now;
      end
    end
  end

  // Transmit side. issue_k_q walks the reply bytes and issues RAM reads; a
  // read issued in one cycle is pending in the next, with its byte index in
  // pend_k_q. A pending read is turned into a reply byte when the output
  // register is free or being emptied; until then the RAM read data holds,
  // because no new read is issued.
  logic [HdrAddrW-1:0] issue_k_q, issue_k_d;
  logic [HdrAddrW-1:0] pend_k_q, pend_k_d;
  logic                pend_q, pend_d;
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_byte_q, out_byte_d;
  logic                out_last_q, out_last_d;
  logic                can_load, load, issue;
  logic [7:0]          ram_rdata;

  assign can_load = !out_valid_q || reply_ready_i;
  assign load     = (state_q == StEmit) && pend_q && can_load;
  assign issue    = (state_q == StEmit) && (issue_k_q < HdrAddrW'(HdrBytes)) &&
                    (!pend_q || can_load);

  // Reply byte for the pending index: RAM data, the local MAC or a constant.
  always_comb begin
    case (pend_k_q) inside
      [6'd6:6'd11]:  out_byte_d = mac_byte(local_mac_q, 3'(pend_k_q - 6'd6));
      [6'd22:6'd27]: out_byte_d = mac_byte(local_mac_q, 3'(pend_k_q - 6'd22));
      6'd18:         out_byte_d = HwAddrLen;
      6'd19:         out_byte_d = ProtoLen;
      6'd20:         out_byte_d = OpReplyHi;
      6'd21:         out_byte_d = OpReplyLo;
      default:       out_byte_d = ram_rdata;
    endcase
  end
  assign out_last_d = (pend_k_q == LastIdx);

  always_comb begin
    state_d     = state_q;
    issue_k_d   = issue_k_q;
    pend_k_d    = pend_k_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;

    if (reply_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      pend_d      = 1'b0;
      if (pend_k_q == LastIdx) begin
        state_d = StIdle;
      end
    end
    if (issue) begin
      pend_d    = 1'b1;
      pend_k_d  = issue_k_q;
      issue_k_d = issue_k_q + HdrAddrW'(1);
    end
    if (reply_due) begin
      state_d   = StEmit;
      issue_k_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      issue_k_q   <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_k_q   <= issue_k_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_k_q <= pend_k_d;
    if (load) begin
      out_byte_q <= out_byte_d;
      out_last_q <= out_last_d;
    end
  end

  assign reply_byte_o  = out_byte_q;
  assign reply_last_o  = out_last_q;
  assign reply_valid_o = out_valid_q;

  // Header store: written by the receive side, read by the transmit side.
  arp_rr_ram #(
    .Width (8),
    .Depth (HdrBytes),
    .AddrW (HdrAddrW)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (in_xfer && (count_q < LENGTH_COUNTER_BITS'(HdrBytes))),
    .waddr_i (count_q[HdrAddrW-1:0]),
    .wdata_i (frame_byte_i),
    .re_i    (issue),
    .raddr_i (src_addr(issue_k_q)),
    .rdata_o (ram_rdata)
  );

  // A pending read only exists while a reply is being sent.
  `ARP_ASSERT_IMPL(a_pend_in_emit, pend_q, state_q == StEmit)
  // The issue counter never runs past the reply length.
  `ARP_ASSERT_IMPL(a_issue_bound, 1'b1, issue_k_q <= HdrAddrW'(HdrBytes))
  // A pending read that cannot be loaded keeps its index for the next cycle.
  `ARP_ASSERT_NEXT(a_pend_hold, pend_q && !can_load, pend_q && $stable(pend_k_q))
  // The byte counter stays saturated inside a long frame.
  `ARP_ASSERT_NEXT(a_count_sat, in_xfer && !frame_last_i && (count_q == '1), count_q == '1)

endmodule

`default_nettype wire
